// ===== src/bcq_pkg.sv =====
// bcq_pkg: shared types, constants and constant tables for the bit crusher
// holds the fractional power-of-two tables built at elaboration
// no dependencies
package bcq_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH     = 2'd2;

    localparam int DEPTH_W = 13;
    localparam int CRUSH_W = 14;
    localparam int PHASE_W = 14;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 13'd4096;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 13'd256;
    localparam logic [DEPTH_W-1:0] QUANT_LIMIT = 13'd4094;
    localparam logic [CRUSH_W-1:0] CRUSH_RESET = 14'd10000;
    localparam logic [CRUSH_W-1:0] RESAMP_LIMIT = 14'd9999;
    localparam logic [PHASE_W-1:0] PHASE_WRAP  = 14'd10000;

    // quantizer number formats
    localparam int FRAC_TABLE_BITS = 8;
    localparam int TAB_DEPTH       = 1 << FRAC_TABLE_BITS;
    localparam int COEF_FRAC       = 30;
    localparam int COEF_W          = 31;
    localparam int NSHIFT_W        = 4;
    localparam int QOUT_W          = 16;

    typedef logic [COEF_W-1:0] coef_tab_t [TAB_DEPTH];

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic               enable;
        logic [DEPTH_W-1:0] bit_depth_q8;
        logic [CRUSH_W-1:0] crush_hundredths;
    } cfg_t;

    // per item quantizer controls
    typedef struct packed {
        logic                quant;
        logic [NSHIFT_W-1:0] n;
        logic [COEF_W-1:0]   p;
        logic [COEF_W-1:0]   q;
    } qctl_t;

    // stage load enables into the lanes
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } lane_en_t;

    // integer square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = v_in;
        r  = 64'd0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 64'd0)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // 2^(k/TAB_DEPTH) in Q1.30 by products of repeated square roots of two
    function automatic coef_tab_t build_p_tab();
        coef_tab_t   tab;
        logic [63:0] roots [FRAC_TABLE_BITS+1];
        logic [63:0] acc;
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= FRAC_TABLE_BITS; j++)
            roots[j] = isqrt64(roots[j-1] << 30);
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            acc = 64'd1 << 30;
            for (int j = 0; j < FRAC_TABLE_BITS; j++)
                if (((k >> j) & 1) != 0)
                    acc = (acc * roots[FRAC_TABLE_BITS-j] + (64'd1 << 29)) >> 30;
            tab[k] = COEF_W'(acc);
        end
        return tab;
    endfunction

    localparam coef_tab_t P_TAB = build_p_tab();

    // rounded inverse 2^60 / P by restoring long division, elaboration only
    function automatic coef_tab_t build_q_tab();
        coef_tab_t   tab;
        logic [63:0] num;
        logic [63:0] den;
        logic [64:0] rem;
        logic [63:0] quo;
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            den = 64'(P_TAB[k]);
            num = (64'd1 << 60) + (den >> 1);
            rem = 65'd0;
            quo = 64'd0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[63:0], num[i]};
                if (rem >= 65'(den))
                begin
                    rem    = rem - 65'(den);
                    quo[i] = 1'b1;
                end
            end
            tab[k] = COEF_W'(quo);
        end
        return tab;
    endfunction

    localparam coef_tab_t Q_TAB = build_q_tab();

    localparam int KSH_L = (FRAC_TABLE_BITS >= 8) ? FRAC_TABLE_BITS - 8 : 0;
    localparam int KSH_R = (FRAC_TABLE_BITS >= 8) ? 0 : 8 - FRAC_TABLE_BITS;

    // rescale the 8 bit depth fraction to a table index
    function automatic logic [FRAC_TABLE_BITS-1:0] frac_index(input logic [7:0] f);
        logic [FRAC_TABLE_BITS+7:0] wide;
        wide = (FRAC_TABLE_BITS + 8)'(f);
        wide = (wide << KSH_L) >> KSH_R;
        return FRAC_TABLE_BITS'(wide);
    endfunction

endpackage

// ===== src/bit_crusher_sample_hold_quantizer.sv =====
// bit_crusher_sample_hold_quantizer: top level of the stereo bit crusher
// configuration registers, pipeline control, two quantizer lanes, output merge
// depends on bcq_pkg, bcq_hold, bcq_lane
//
// Usage:
//   s_axis carries one stereo frame per item: left sample in the low half of
//   tdata, right sample above it. m_axis returns one crushed frame per item in
//   the same layout. cfg writes enable (0), bit_depth_q8 (1) and
//   crush_hundredths (2); cfg_ready is always high, other indexes are dropped.
//   Write configuration only while no item is in flight.
//   A frame accepted on s_axis loads the entry register, then passes
//   through two multiplier stages and a rounding stage before it is
//   shown on m_axis.
//   Throughput: one frame per cycle while m_axis_tready is high, set by the
//   four stage pipeline with one multiplier in each multiplier stage of a lane.
//   Reset: pipeline empties, registers go to enable 0, bit depth 4096,
//   crush 10000, held frame to zero and phase to a full period so the first
//   resampled frame is captured.
//   Stall: each stage keeps its item while the next is full and held; bubbles
//   close up, and s_axis_tready falls only when all four stages hold an item.
module bit_crusher_sample_hold_quantizer #(
    parameter int SAMPLE_WIDTH = 24,
    localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [TDATA_W-1:0]             s_axis_tdata,   // sample_left, sample_right
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [TDATA_W-1:0]             m_axis_tdata,   // out_left, out_right, zero pad
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bcq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic can1, can2, can3, can4;
    logic take;

    logic signed [SAMPLE_WIDTH-1:0] in_left;
    logic signed [SAMPLE_WIDTH-1:0] in_right;
    logic signed [SAMPLE_WIDTH-1:0] sel_left;
    logic signed [SAMPLE_WIDTH-1:0] sel_right;
    qctl_t                          qctl;

    logic signed [SAMPLE_WIDTH-1:0] x1_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_right_reg;
    qctl_t                          ctl1_reg;

    lane_en_t                       lane_en;
    logic signed [SAMPLE_WIDTH-1:0] y_left;
    logic signed [SAMPLE_WIDTH-1:0] y_right;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENABLE:    cfg_next.enable           = cfg_data[0];
                REG_BIT_DEPTH: cfg_next.bit_depth_q8     = cfg_data[DEPTH_W-1:0];
                REG_CRUSH:     cfg_next.crush_hundredths = cfg_data[CRUSH_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // pipeline flow control, each stage frees up when the next one moves
    always_comb
    begin
        can4    = !v4_reg || m_axis_tready;
        can3    = !v3_reg || can4;
        can2    = !v2_reg || can3;
        can1    = !v1_reg || can2;
        take    = s_axis_tvalid && can1;
        v1_next = can1 ? s_axis_tvalid : v1_reg;
        v2_next = can2 ? v1_reg : v2_reg;
        v3_next = can3 ? v2_reg : v3_reg;
        v4_next = can4 ? v3_reg : v4_reg;
        lane_en.ld_a = can2;
        lane_en.ld_b = can3;
        lane_en.ld_c = can4;
    end

    assign s_axis_tready = can1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable           <= 1'b0;
            cfg_reg.bit_depth_q8     <= DEPTH_RESET;
            cfg_reg.crush_hundredths <= CRUSH_RESET;
            v1_reg                   <= 1'b0;
            v2_reg                   <= 1'b0;
            v3_reg                   <= 1'b0;
            v4_reg                   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            v3_reg  <= v3_next;
            v4_reg  <= v4_next;
        end
    end

    // input unpack
    assign in_left  = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_right = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    // sample and hold with mode decode
    bcq_hold #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .in_left   (in_left),
        .in_right  (in_right),
        .sel_left  (sel_left),
        .sel_right (sel_right),
        .qctl      (qctl)
    );

    // entry register
    always_ff @(posedge clk)
    begin
        if (can1)
        begin
            x1_left_reg  <= sel_left;
            x1_right_reg <= sel_right;
            ctl1_reg     <= qctl;
        end
    end

    // one quantizer lane per channel
    bcq_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lane_left (
        .clk (clk),
        .en  (lane_en),
        .x   (x1_left_reg),
        .ctl (ctl1_reg),
        .y   (y_left)
    );

    bcq_lane #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lane_right (
        .clk (clk),
        .en  (lane_en),
        .x   (x1_right_reg),
        .ctl (ctl1_reg),
        .y   (y_right)
    );

    // merge lane results into the output item
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = TDATA_W'({y_right, y_left});

endmodule

// ===== src/bcq_hold.sv =====
// bcq_hold: phase accumulator, held frame and per item mode decode
// selects the frame that enters the quantizer lanes
// depends on bcq_pkg
module bcq_hold #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bcq_pkg::cfg_t                  cfg,
    input  logic                           take,
    input  logic signed [SAMPLE_WIDTH-1:0] in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] in_right,
    output logic signed [SAMPLE_WIDTH-1:0] sel_left,
    output logic signed [SAMPLE_WIDTH-1:0] sel_right,
    output bcq_pkg::qctl_t                 qctl
);
    import bcq_pkg::*;

    logic [PHASE_W-1:0]             phase_reg;
    logic [PHASE_W-1:0]             phase_next;
    logic signed [SAMPLE_WIDTH-1:0] held_left_reg;
    logic signed [SAMPLE_WIDTH-1:0] held_left_next;
    logic signed [SAMPLE_WIDTH-1:0] held_right_reg;
    logic signed [SAMPLE_WIDTH-1:0] held_right_next;

    logic               quant;
    logic               resamp;
    logic               active;
    logic [CRUSH_W-1:0] step;
    logic [PHASE_W:0]   phase_sum;
    logic               wrap;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] excess;
    logic [FRAC_TABLE_BITS-1:0] k;

    // mode decode
    assign quant  = cfg.bit_depth_q8 < QUANT_LIMIT;
    assign resamp = cfg.crush_hundredths < RESAMP_LIMIT;
    assign active = cfg.enable && (quant || resamp);

    // phase step, zero crush runs at the slowest rate
    always_comb
    begin
        step      = (cfg.crush_hundredths == '0) ? CRUSH_W'(1) : cfg.crush_hundredths;
        phase_sum = (PHASE_W + 1)'(phase_reg) + (PHASE_W + 1)'(step);
        wrap      = phase_sum >= (PHASE_W + 1)'(PHASE_WRAP);
    end

    // sample and hold update
    always_comb
    begin
        phase_next      = phase_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        if (take && active && resamp)
        begin
            if (wrap)
            begin
                phase_next      = PHASE_W'(phase_sum - (PHASE_W + 1)'(PHASE_WRAP));
                held_left_next  = in_left;
                held_right_next = in_right;
            end
            else
            begin
                phase_next = PHASE_W'(phase_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_WRAP;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    // frame that goes on to the lanes
    always_comb
    begin
        if (active && resamp && !wrap)
        begin
            sel_left  = held_left_reg;
            sel_right = held_right_reg;
        end
        else
        begin
            sel_left  = in_left;
            sel_right = in_right;
        end
    end

    // bit depth split into whole shift and table index
    always_comb
    begin
        depth      = (cfg.bit_depth_q8 < DEPTH_MIN) ? DEPTH_MIN : cfg.bit_depth_q8;
        excess     = depth - DEPTH_MIN;
        k          = frac_index(excess[7:0]);
        qctl.quant = active && quant;
        qctl.n     = excess[8 +: NSHIFT_W];
        qctl.p     = P_TAB[k];
        qctl.q     = Q_TAB[k];
    end

endmodule

// ===== src/bcq_lane.sv =====
// bcq_lane: one channel of the rounding quantizer, three register stages
// magnitude times 2^f, rescale and multiply by inverse, round and saturate
// depends on bcq_pkg
module bcq_lane #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  bcq_pkg::lane_en_t              en,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  bcq_pkg::qctl_t                 ctl,
    output logic signed [SAMPLE_WIDTH-1:0] y
);
    import bcq_pkg::*;

    localparam int F      = SAMPLE_WIDTH - 1;
    localparam int PW     = SAMPLE_WIDTH + COEF_W;
    localparam int OW     = QOUT_W + COEF_W + 1;
    localparam int D_BASE = COEF_FRAC - F;
    localparam logic [OW-1:0] LIM_NEG = OW'(1) << F;
    localparam logic [OW-1:0] LIM_POS = LIM_NEG - OW'(1);

    // stage a registers
    logic [PW-1:0]                  prod_a_reg;
    logic                           neg_a_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_a_reg;
    qctl_t                          ctl_a_reg;
    // stage b registers
    logic [OW-1:0]                  o_b_reg;
    logic                           neg_b_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_b_reg;
    logic                           quant_b_reg;
    logic [NSHIFT_W-1:0]            n_b_reg;
    // stage c register
    logic signed [SAMPLE_WIDTH-1:0] y_c_reg;

    logic [SAMPLE_WIDTH-1:0]        m;
    logic [PW-1:0]                  prod;
    logic [5:0]                     s_sh;
    logic [PW:0]                    rnd;
    logic [QOUT_W-1:0]              qv;
    logic [OW-1:0]                  o;
    logic signed [6:0]              d_val;
    logic [5:0]                     dsh;
    logic [OW-1:0]                  mag;
    logic [OW-1:0]                  clip;
    logic signed [SAMPLE_WIDTH-1:0] res;

    // stage a: magnitude scaled by the fractional power
    always_comb
    begin
        m    = x[F] ? SAMPLE_WIDTH'(-x) : SAMPLE_WIDTH'(x);
        prod = PW'(m) * PW'(ctl.p);
    end

    // stage b: round to the step count, then multiply by the inverse
    always_comb
    begin
        s_sh = 6'(COEF_FRAC + F) - 6'(ctl_a_reg.n);
        rnd  = (PW + 1)'(prod_a_reg) + ((PW + 1)'(1) << (s_sh - 6'd1));
        qv   = QOUT_W'(rnd >> s_sh);
        o    = OW'(qv) * OW'(ctl_a_reg.q);
    end

    // stage c: final rounding shift, sign and saturation
    always_comb
    begin
        d_val = 7'(D_BASE + int'(n_b_reg));
        if (d_val > 7'sd0)
        begin
            dsh = 6'(d_val);
            mag = (o_b_reg + (OW'(1) << (dsh - 6'd1))) >> dsh;
        end
        else
        begin
            dsh = 6'(-d_val);
            mag = o_b_reg << dsh;
        end
        if (neg_b_reg)
        begin
            clip = (mag > LIM_NEG) ? LIM_NEG : mag;
            res  = SAMPLE_WIDTH'(-clip);
        end
        else
        begin
            clip = (mag > LIM_POS) ? LIM_POS : mag;
            res  = SAMPLE_WIDTH'(clip);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_a)
        begin
            prod_a_reg <= prod;
            neg_a_reg  <= x[F];
            x_a_reg    <= x;
            ctl_a_reg  <= ctl;
        end
        if (en.ld_b)
        begin
            o_b_reg     <= o;
            neg_b_reg   <= neg_a_reg;
            x_b_reg     <= x_a_reg;
            quant_b_reg <= ctl_a_reg.quant;
            n_b_reg     <= ctl_a_reg.n;
        end
        if (en.ld_c)
        begin
            y_c_reg <= quant_b_reg ? res : x_b_reg;
        end
    end

    assign y = y_c_reg;

endmodule

// ===== src/bcq_checker.sv =====
// bcq_checker: port level assertions for the bit crusher top level
// bound to bit_crusher_sample_hold_quantizer, needs only its ports
module bcq_checker #(
    parameter int TDATA_W = 48
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [TDATA_W-1:0]             m_axis_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // items accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg + 3'(in_fire) - 3'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // no result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> cnt_reg != 3'd0)
        else $error("result delivered with no item in flight");

    // at most four items in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("more items in flight than pipeline stages");

    // input side only blocks when a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output stall");

    // configuration changes only with the pipeline empty
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> cnt_reg == 3'd0)
        else $error("configuration written with items in flight");

endmodule

bind bit_crusher_sample_hold_quantizer bcq_checker #(
    .TDATA_W(TDATA_W)
) u_bcq_checker (.*);
